FILE: hdl/linear_fit_r_squared_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear fit block
// Implication checks that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef LINEAR_FIT_R_SQUARED_TOP_ASSERT_SVH
`define LINEAR_FIT_R_SQUARED_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define LFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("linear fit assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define LFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("linear fit assertion failed");
`else
`define LFR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/lfr_pkg.sv
// ----------------------------------------------------------------------------
// lfr_pkg
// Types, constants and command codes shared by the linear fit modules.
// ----------------------------------------------------------------------------
package lfr_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int CNT_W       = 7;
  localparam int SUM1_W      = 22;
  localparam int SUMSQ_W     = 37;
  localparam int SUMZR_W     = 38;
  localparam int MW          = 48;   // fit multiplier operand width
  localparam int PW          = 96;   // fit multiplier product width
  localparam int MUL_DIGITS  = 3;    // 16-bit digits of the multiplier operand
  localparam int SQRT_STEPS  = 16;
  localparam int STEP_W      = $clog2(SQRT_STEPS + 1);
  localparam int DIV_STEPS   = 128;
  localparam int DIVN_W      = 128;
  localparam int DIVD_W      = 96;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic        [16:0] r_squared;
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic        [6:0]  point_count;
    logic        [1:0]  status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_SQRT, S_ZZ, S_RR, S_ZR,
    S_MUL_GO, S_MUL_RUN, S_MUL_WR, S_CHECK,
    S_DIV_GO, S_DIV_RUN, S_DIV_WR, S_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SQX, OP_SQY, OP_SQRT,
    OP_ACC_ZZ, OP_ACC_RR, OP_ACC_ZR,
    OP_MUL_GO, OP_MUL_STEP, OP_MUL_WR,
    OP_DIV_GO, OP_DIV_WR, OP_FIN
  } op_t;

  typedef enum logic [3:0] {
    J_N_ZZ, J_ZZ, J_N_RR, J_RR, J_N_ZR, J_ZR,
    J_N_SXX, J_SLOPE, J_R_SXX, J_SXY_Z, J_ICPT,
    J_SXY2, J_SXX_SYY, J_R2
  } job_t;

  typedef struct packed {
    op_t  op;
    job_t job;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic degen;
    logic syy_pos;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/lfr_div.sv
// ----------------------------------------------------------------------------
// lfr_div
// Restoring divider, one quotient bit per cycle over the full dividend.
// ----------------------------------------------------------------------------
`include "linear_fit_r_squared_top_assert.svh"
module lfr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lfr_pkg::DIVN_W-1:0] dividend,
  input  logic [lfr_pkg::DIVD_W-1:0] divisor,
  output logic                       done,
  output logic [lfr_pkg::DIVN_W-1:0] quo
);
  import lfr_pkg::*;

  localparam int CW = $clog2(DIV_STEPS);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [DIVN_W-1:0] num_r;
  logic [DIVD_W-1:0] den_r;
  logic [DIVD_W:0]   rem_r;
  logic [DIVN_W-1:0] quo_r;
  logic [DIVD_W:0]   rem_sh;
  logic [DIVD_W+1:0] diff;

  // The remainder stays below the divisor, so its top bit is always clear.
  assign rem_sh = {rem_r[DIVD_W-1:0], num_r[DIVN_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DIVN_W-2:0], 1'b0};
      if (!diff[DIVD_W+1]) begin
        rem_r <= diff[DIVD_W:0];
        quo_r <= {quo_r[DIVN_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[DIVN_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

  `LFR_ASSERT_NEXT(a_div_start_busy, clk, rst_n, start, busy_r)
  `LFR_ASSERT_SAME(a_div_done_idle, clk, rst_n, done_r, !busy_r)

endmodule

FILE: hdl/lfr_ctrl.sv
// ----------------------------------------------------------------------------
// lfr_ctrl
// Sequencer for per-point accumulation and the end-of-event fit.
// ----------------------------------------------------------------------------
`include "linear_fit_r_squared_top_assert.svh"
module lfr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lfr_pkg::sts_t sts,
  output lfr_pkg::cmd_t cmd
);
  import lfr_pkg::*;

  state_t            state_r, state_nxt;
  job_t              job_r, job_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      job_r   <= J_N_ZZ;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    cnt_nxt   = cnt_r;
    cmd.op    = OP_NONE;
    cmd.job   = job_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_SQX;
        end
      end
      S_SQX: begin
        cmd.op    = OP_SQX;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.op    = OP_SQY;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op  = OP_SQRT;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(SQRT_STEPS - 1)) state_nxt = S_ZZ;
      end
      S_ZZ: begin
        cmd.op    = OP_ACC_ZZ;
        state_nxt = S_RR;
      end
      S_RR: begin
        cmd.op    = OP_ACC_RR;
        state_nxt = S_ZR;
      end
      S_ZR: begin
        cmd.op = OP_ACC_ZR;
        if (sts.last) begin
          job_nxt   = J_N_ZZ;
          state_nxt = S_MUL_GO;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MUL_GO: begin
        cmd.op    = OP_MUL_GO;
        cnt_nxt   = '0;
        state_nxt = S_MUL_RUN;
      end
      S_MUL_RUN: begin
        cmd.op  = OP_MUL_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(MUL_DIGITS - 1)) state_nxt = S_MUL_WR;
      end
      S_MUL_WR: begin
        cmd.op    = OP_MUL_WR;
        state_nxt = S_MUL_GO;
        case (job_r)
          J_N_ZZ:    job_nxt = J_ZZ;
          J_ZZ:      job_nxt = J_N_RR;
          J_N_RR:    job_nxt = J_RR;
          J_RR:      job_nxt = J_N_ZR;
          J_N_ZR:    job_nxt = J_ZR;
          J_ZR:      state_nxt = S_CHECK;
          J_N_SXX: begin
            job_nxt   = J_SLOPE;
            state_nxt = S_DIV_GO;
          end
          J_R_SXX:   job_nxt = J_SXY_Z;
          J_SXY_Z: begin
            job_nxt   = J_ICPT;
            state_nxt = S_DIV_GO;
          end
          J_SXY2:    job_nxt = J_SXX_SYY;
          J_SXX_SYY: begin
            job_nxt   = J_R2;
            state_nxt = S_DIV_GO;
          end
          default:   state_nxt = S_FIN;
        endcase
      end
      S_CHECK: begin
        if (sts.degen) begin
          state_nxt = S_FIN;
        end else begin
          job_nxt   = J_N_SXX;
          state_nxt = S_MUL_GO;
        end
      end
      S_DIV_GO: begin
        cmd.op    = OP_DIV_GO;
        state_nxt = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        if (sts.div_done) state_nxt = S_DIV_WR;
      end
      S_DIV_WR: begin
        cmd.op    = OP_DIV_WR;
        state_nxt = S_FIN;
        case (job_r)
          J_SLOPE: begin
            job_nxt   = J_R_SXX;
            state_nxt = S_MUL_GO;
          end
          J_ICPT: begin
            if (sts.syy_pos) begin
              job_nxt   = J_SXY2;
              state_nxt = S_MUL_GO;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.op    = OP_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `LFR_ASSERT_NEXT(a_accept_starts_point, clk, rst_n, in_valid && in_ready, state_r == S_SQX)
  `LFR_ASSERT_SAME(a_mul_digit_count, clk, rst_n, state_r == S_MUL_WR,
                   cnt_r == STEP_W'(MUL_DIGITS))
  `LFR_ASSERT_SAME(a_fin_needs_room, clk, rst_n, cmd.op == OP_FIN, sts.out_free)

endmodule

FILE: hdl/lfr_dp.sv
// ----------------------------------------------------------------------------
// lfr_dp
// Datapath: radius root, moment sums, fit multiplier, divider and result.
// ----------------------------------------------------------------------------
`include "linear_fit_r_squared_top_assert.svh"
module lfr_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  lfr_pkg::cmd_t      cmd,
  output lfr_pkg::sts_t      sts,
  input  lfr_pkg::in_item_t  in_data,
  input  logic               out_ready,
  output logic               out_valid,
  output lfr_pkg::out_item_t out_data
);
  import lfr_pkg::*;

  // Point and radius
  in_item_t            pt_r;
  logic                keep_r;
  logic [31:0]         sq_r;
  logic [31:0]         res_r;
  logic [31:0]         bit_r;
  logic [31:0]         trial;
  logic signed [16:0]  sm_a, sm_b;
  logic signed [33:0]  sm_p;

  // Moment sums
  logic [CNT_W-1:0]    count_r;
  logic [SUM1_W-1:0]   sum_z_r, sum_r_r;
  logic [SUMSQ_W-1:0]  sum_zz_r, sum_rr_r;
  logic [SUMZR_W-1:0]  sum_zr_r;
  logic                ovf_r;

  // Fit
  logic [MW-1:0]       mop_a, mop_b, mag_a, mag_b;
  logic [MW-1:0]       ma_r, mb_r;
  logic                mneg_r;
  logic [127:0]        acc_r;
  logic [63:0]         pp;
  logic [PW-1:0]       prod_mag, prod, diff;
  logic [PW-1:0]       t_r, dn_r, inum_r, num2_r, den2_r;
  logic [MW-1:0]       sxx_r, syy_r, sxy_r;

  // Division
  logic [DIVD_W-1:0]   dnum, dden, dmag;
  logic                dneg_r;
  logic                div_done;
  logic [DIVN_W-1:0]   div_q;
  logic [DIVN_W:0]     q1;
  logic [DIVN_W-1:0]   v;
  logic                v_hi;
  logic [31:0]         pos32, neg32, res32;
  logic [16:0]         r2sat;
  logic [31:0]         slope_r, icpt_r;
  logic [16:0]         r2_r;

  logic                out_valid_r;
  out_item_t           out_r;
  logic                degen, syy_pos, bad_r2;

  // Shared small multiplier for the squares and the per-point products.
  always_comb begin
    sm_a = {pt_r.pos_z[15], pt_r.pos_z};
    sm_b = {pt_r.pos_z[15], pt_r.pos_z};
    case (cmd.op)
      OP_SQX: begin
        sm_a = {pt_r.pos_x[15], pt_r.pos_x};
        sm_b = {pt_r.pos_x[15], pt_r.pos_x};
      end
      OP_SQY: begin
        sm_a = {pt_r.pos_y[15], pt_r.pos_y};
        sm_b = {pt_r.pos_y[15], pt_r.pos_y};
      end
      OP_ACC_RR: begin
        sm_a = {1'b0, res_r[15:0]};
        sm_b = {1'b0, res_r[15:0]};
      end
      OP_ACC_ZR: sm_b = {1'b0, res_r[15:0]};
      default: ;
    endcase
  end

  assign sm_p  = sm_a * sm_b;
  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        pt_r   <= in_data;
        keep_r <= (count_r != CNT_W'(MAX_POINTS));
      end
      OP_SQX: sq_r <= sm_p[31:0];
      OP_SQY: begin
        sq_r  <= sq_r + sm_p[31:0];
        res_r <= '0;
        bit_r <= 32'h4000_0000;
      end
      OP_SQRT: begin
        if (sq_r >= trial) begin
          sq_r  <= sq_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      sum_z_r  <= '0;
      sum_r_r  <= '0;
      sum_zz_r <= '0;
      sum_rr_r <= '0;
      sum_zr_r <= '0;
      ovf_r    <= 1'b0;
    end else begin
      case (cmd.op)
        OP_ACC_ZZ: begin
          if (keep_r) begin
            count_r  <= count_r + 1'b1;
            sum_z_r  <= sum_z_r + {{6{pt_r.pos_z[15]}}, pt_r.pos_z};
            sum_r_r  <= sum_r_r + {6'b0, res_r[15:0]};
            sum_zz_r <= sum_zz_r + {5'b0, sm_p[31:0]};
          end else begin
            ovf_r <= 1'b1;
          end
        end
        OP_ACC_RR: if (keep_r) sum_rr_r <= sum_rr_r + {5'b0, sm_p[31:0]};
        OP_ACC_ZR: if (keep_r) sum_zr_r <= sum_zr_r + {{5{sm_p[32]}}, sm_p[32:0]};
        OP_FIN: begin
          count_r  <= '0;
          sum_z_r  <= '0;
          sum_r_r  <= '0;
          sum_zz_r <= '0;
          sum_rr_r <= '0;
          sum_zr_r <= '0;
          ovf_r    <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Operand pairs of the fit multiplications.
  always_comb begin
    mop_a = '0;
    mop_b = '0;
    case (cmd.job)
      J_N_ZZ: begin
        mop_a = {41'b0, count_r};
        mop_b = {11'b0, sum_zz_r};
      end
      J_ZZ: begin
        mop_a = {{26{sum_z_r[21]}}, sum_z_r};
        mop_b = {{26{sum_z_r[21]}}, sum_z_r};
      end
      J_N_RR: begin
        mop_a = {41'b0, count_r};
        mop_b = {11'b0, sum_rr_r};
      end
      J_RR: begin
        mop_a = {26'b0, sum_r_r};
        mop_b = {26'b0, sum_r_r};
      end
      J_N_ZR: begin
        mop_a = {41'b0, count_r};
        mop_b = {{10{sum_zr_r[37]}}, sum_zr_r};
      end
      J_ZR: begin
        mop_a = {{26{sum_z_r[21]}}, sum_z_r};
        mop_b = {26'b0, sum_r_r};
      end
      J_N_SXX: begin
        mop_a = {41'b0, count_r};
        mop_b = sxx_r;
      end
      J_R_SXX: begin
        mop_a = {26'b0, sum_r_r};
        mop_b = sxx_r;
      end
      J_SXY_Z: begin
        mop_a = sxy_r;
        mop_b = {{26{sum_z_r[21]}}, sum_z_r};
      end
      J_SXY2: begin
        mop_a = sxy_r;
        mop_b = sxy_r;
      end
      J_SXX_SYY: begin
        mop_a = sxx_r;
        mop_b = syy_r;
      end
      default: ;
    endcase
  end

  assign mag_a    = mop_a[MW-1] ? (MW'(0) - mop_a) : mop_a;
  assign mag_b    = mop_b[MW-1] ? (MW'(0) - mop_b) : mop_b;
  assign pp       = ma_r * mb_r[15:0];
  // Digits enter at the top and the accumulator moves down, so the full
  // product ends up 32 bits above the bottom after the last digit.
  assign prod_mag = acc_r[127:32];
  assign prod     = mneg_r ? (PW'(0) - prod_mag) : prod_mag;
  assign diff     = t_r - prod;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_MUL_GO: begin
        ma_r   <= mag_a;
        mb_r   <= mag_b;
        mneg_r <= mop_a[MW-1] ^ mop_b[MW-1];
        acc_r  <= '0;
      end
      OP_MUL_STEP: begin
        acc_r <= {16'b0, acc_r[127:16]} + {pp, 64'b0};
        mb_r  <= mb_r >> 16;
      end
      OP_MUL_WR: begin
        case (cmd.job)
          J_ZZ:      sxx_r  <= diff[MW-1:0];
          J_RR:      syy_r  <= diff[MW-1:0];
          J_ZR:      sxy_r  <= diff[MW-1:0];
          J_N_SXX:   dn_r   <= prod;
          J_SXY_Z:   inum_r <= diff;
          J_SXY2:    num2_r <= prod;
          J_SXX_SYY: den2_r <= prod;
          default:   t_r    <= prod;
        endcase
      end
      default: ;
    endcase
  end

  // Divider operands and rounding of the quotient.
  always_comb begin
    dnum = '0;
    dden = '0;
    case (cmd.job)
      J_SLOPE: begin
        dnum = {{48{sxy_r[MW-1]}}, sxy_r};
        dden = {48'b0, sxx_r};
      end
      J_ICPT: begin
        dnum = inum_r;
        dden = dn_r;
      end
      J_R2: begin
        dnum = num2_r;
        dden = den2_r;
      end
      default: ;
    endcase
  end

  assign dmag = dnum[DIVD_W-1] ? (DIVD_W'(0) - dnum) : dnum;

  lfr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == OP_DIV_GO),
    .dividend ({15'b0, dmag, 17'b0}),
    .divisor  (dden),
    .done     (div_done),
    .quo      (div_q)
  );

  // The quotient carries one extra fraction bit; add one and drop it.
  assign q1    = {1'b0, div_q} + {{DIVN_W{1'b0}}, 1'b1};
  assign v     = q1[DIVN_W:1];
  assign v_hi  = |v[DIVN_W-1:31];
  assign pos32 = v_hi ? 32'h7FFF_FFFF : {1'b0, v[30:0]};
  assign neg32 = v_hi ? 32'h8000_0000 : (32'd0 - v[31:0]);
  assign res32 = dneg_r ? neg32 : pos32;
  assign r2sat = (|v[DIVN_W-1:17] || (v[16] && |v[15:0])) ? 17'h10000 : v[16:0];

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_DIV_GO: dneg_r <= dnum[DIVD_W-1];
      OP_DIV_WR: begin
        case (cmd.job)
          J_SLOPE: slope_r <= res32;
          J_ICPT:  icpt_r  <= res32;
          default: r2_r    <= r2sat;
        endcase
      end
      default: ;
    endcase
  end

  assign degen   = (count_r < CNT_W'(2)) || sxx_r[MW-1] || (sxx_r == '0);
  assign syy_pos = !syy_r[MW-1] && (syy_r != '0);
  assign bad_r2  = degen || !syy_pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_FIN) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FIN) begin
      out_r.r_squared   <= bad_r2 ? 17'd0 : r2_r;
      out_r.slope       <= degen ? 32'sd0 : $signed(slope_r);
      out_r.intercept   <= degen ? 32'sd0 : $signed(icpt_r);
      out_r.point_count <= count_r;
      out_r.status      <= ovf_r ? ST_OVF : (bad_r2 ? ST_DEGEN : ST_OK);
    end
  end

  assign sts.last     = pt_r.last_point;
  assign sts.degen    = degen;
  assign sts.syy_pos  = syy_pos;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

  `LFR_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(MAX_POINTS))
  `LFR_ASSERT_SAME(a_ovf_only_full, clk, rst_n, $rose(ovf_r), count_r == CNT_W'(MAX_POINTS))

endmodule

FILE: hdl/linear_fit_r_squared_top.sv
// ----------------------------------------------------------------------------
// linear_fit_r_squared_top
// Least-squares fit of radius against z with R squared over one event.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | pos_x, pos_y, pos_z, last_point
//  out_    | output    | out_valid / out_ready | r_squared, slope, intercept,
//          |           |                       | point_count, status
//
//  A new point is taken only once the last is through: the accepting cycle,
//  two squares, 16 steps of the bit-serial radius root and three accumulates.
//  The last point adds the fit: up to eleven 3-digit multiplications and
//  three 128-step divisions.
//  Reset is synchronous and clears the sums; no clearing pass is needed.
//  A finished result waits in the output register; the next event's points
//  are taken meanwhile, and only a second fit stalls until it is taken.
module linear_fit_r_squared_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lfr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lfr_pkg::out_item_t out_data
);
  import lfr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
